// File: hdl/mts_pkg.sv
// Package for the melody tone sequencer: sizes, codes, transaction structs and helpers.
// No dependencies; every other file of the block imports it.
`default_nettype none

package mts_pkg;

  localparam int MAX_NOTES   = 32;
  localparam int NOTE_AW     = $clog2(MAX_NOTES);
  localparam int IDX_W       = 6;
  localparam int LEN_W       = 6;
  localparam int RATE_W      = 10;
  localparam int ENTRY_IDX_W = 5;
  localparam int FREQ_W      = 16;
  localparam int MS_W        = 16;
  localparam int TICK_W      = 32;
  localparam int SCALE_W     = 28;
  localparam int SCALE_SHIFT = 27;
  localparam int PROD_W      = MS_W + SCALE_W;
  localparam int OFF_W       = PROD_W - SCALE_SHIFT;
  localparam int RECIP_SHIFT = 10;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_W   = 1;

  localparam logic [SCALE_W-1:0] RECIP_1000 = 28'd137438954;
  localparam logic [RATE_W-1:0]  RATE_RESET = 10'd100;

  localparam logic [REG_IDX_W-1:0] REG_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_RATE   = 1'b1;

  localparam logic [1:0] FUNC_STEP  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  localparam logic [2:0] CODE_IDLE  = 3'd0;
  localparam logic [2:0] CODE_START = 3'd1;
  localparam logic [2:0] CODE_PLAY  = 3'd2;
  localparam logic [2:0] CODE_PAUSE = 3'd3;
  localparam logic [2:0] CODE_STOP  = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_PLAY  = 5'b00100,
    PH_PAUSE = 5'b01000,
    PH_STOP  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0]             func;
    logic [TICK_W-1:0]      now_ticks;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [FREQ_W-1:0]      entry_freq_hz;
    logic [FREQ_W-1:0]      entry_duty_us;
    logic [MS_W-1:0]        entry_duration_ms;
    logic [MS_W-1:0]        entry_pause_ms;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_freq_hz;
    logic [FREQ_W-1:0] tone_duty_us;
    logic              tone_on;
    logic [2:0]        phase;
    logic [IDX_W-1:0]  note_position;
    logic              start_rejected;
  } out_item_t;

  typedef struct packed {
    logic [MS_W-1:0]   pause_ms;
    logic [MS_W-1:0]   duration_ms;
    logic [FREQ_W-1:0] duty_us;
    logic [FREQ_W-1:0] freq_hz;
  } note_t;

  typedef struct packed {
    logic [LEN_W-1:0]   melody_length;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  // ticks = (ms * scale) >> SCALE_SHIFT equals ms * rate / 1000, truncated
  function automatic logic [SCALE_W-1:0] rate_scale(input logic [RATE_W-1:0] rate);
    logic [RATE_W+SCALE_W-1:0] p;
    p = (RATE_W+SCALE_W)'(rate) * (RATE_W+SCALE_W)'(RECIP_1000);
    return SCALE_W'(p >> RECIP_SHIFT) + SCALE_W'(1);
  endfunction

  function automatic logic [2:0] phase_code(input phase_e ph);
    logic [2:0] c;
    case (ph)
      PH_IDLE:  c = CODE_IDLE;
      PH_START: c = CODE_START;
      PH_PLAY:  c = CODE_PLAY;
      PH_PAUSE: c = CODE_PAUSE;
      PH_STOP:  c = CODE_STOP;
      default:  c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/melody_tone_sequencer.sv
// Top level of the melody tone sequencer: handshake, note table, phase machine, registers.
// Depends on mts_pkg, mts_cfg, mts_note_mem and mts_exec.
//
// Plays a melody stored in a 32-entry note table by producing tone generator settings.
// Every input transaction (note write, start, stop, or step with the current tick) gives
// exactly one result transaction with the state after it. One transaction is taken per
// clock cycle unless the output stalls. The note table is read at the accepting edge, at
// the current note index; the item then waits in a stage register while the phase machine
// runs with the ms-to-tick multiply and the deadline compare, and its result is loaded into
// the output register once that register is free or drained. While a result waits in the
// output register one more transaction can enter; further input is held off until the
// output drains. The note table has no reset; a note must be written before it is played.
`default_nettype none

module melody_tone_sequencer import mts_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t             cfg;
  logic             a_valid_q;
  in_item_t         a_item_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             adv;
  logic             in_fire;
  logic [IDX_W-1:0] rd_addr;
  note_t            note;
  note_t            wr_note;
  out_item_t        result;

  assign adv        = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign wr_note.freq_hz     = in_data_i.entry_freq_hz;
  assign wr_note.duty_us     = in_data_i.entry_duty_us;
  assign wr_note.duration_ms = in_data_i.entry_duration_ms;
  assign wr_note.pause_ms    = in_data_i.entry_pause_ms;

  mts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mts_note_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_fire && (in_data_i.func == FUNC_WRITE)),
    .wr_addr_i (in_data_i.entry_index),
    .wr_data_i (wr_note),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (note)
  );

  mts_exec u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (a_item_q),
    .note_i    (note),
    .adv_i     (adv),
    .rd_addr_o (rd_addr),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (adv) begin
        a_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= in_data_i;
    end
    if (adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hdl/mts_cfg.sv
// Configuration registers of the melody tone sequencer behind an APB-style port.
// Depends on mts_pkg; also derives the ms-to-tick scale factor from the tick rate.
`default_nettype none

module mts_cfg import mts_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [LEN_W-1:0]     len_q;
  logic [RATE_W-1:0]    rate_q;
  logic [SCALE_W-1:0]   scale_q;
  logic                 wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      rate_q  <= RATE_RESET;
      scale_q <= rate_scale(RATE_RESET);
    end else if (wr) begin
      case (reg_idx)
        REG_LENGTH: len_q <= pwdata[LEN_W-1:0];
        REG_RATE: begin
          rate_q  <= pwdata[RATE_W-1:0];
          scale_q <= rate_scale(pwdata[RATE_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LENGTH: prdata = APB_DW'(len_q);
      REG_RATE:   prdata = APB_DW'(rate_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.melody_length = len_q;
  assign cfg_o.scale         = scale_q;

endmodule

`default_nettype wire

// File: hdl/mts_note_mem.sv
// Note table of the melody tone sequencer: one write port, one registered read port.
// Depends on mts_pkg; reads beyond the table return an all-zero note.
`default_nettype none

module mts_note_mem import mts_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_en_i,
  input  wire logic [ENTRY_IDX_W-1:0] wr_addr_i,
  input  note_t                       wr_data_i,
  input  wire logic                   rd_en_i,
  input  wire logic [IDX_W-1:0]       rd_addr_i,
  output note_t                       rd_data_o
);

  note_t mem [MAX_NOTES];
  note_t rd_q;
  logic  oob_q;
  logic  wr_ok;

  assign wr_ok = (int'(wr_addr_i) < MAX_NOTES);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok) begin
      mem[NOTE_AW'(wr_addr_i)] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i[NOTE_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oob_q <= 1'b0;
    end else if (rd_en_i) begin
      oob_q <= (int'(rd_addr_i) >= MAX_NOTES);
    end
  end

  assign rd_data_o = oob_q ? '0 : rd_q;

endmodule

`default_nettype wire

// File: hdl/mts_exec.sv
// Phase machine and playback state of the melody tone sequencer.
// Depends on mts_pkg; takes the note read for the item and yields its result.
`default_nettype none

module mts_exec import mts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cfg_t                  cfg_i,
  input  in_item_t              item_i,
  input  note_t                 note_i,
  input  wire logic             adv_i,
  output logic      [IDX_W-1:0] rd_addr_o,
  output out_item_t             result_o
);

  phase_e             phase_q, phase_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [TICK_W-1:0]  base_q, base_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [FREQ_W-1:0]  freq_q, freq_d;
  logic [FREQ_W-1:0]  duty_q, duty_d;
  logic               run_q, run_d;
  logic               rej;
  logic [TICK_W-1:0]  deadline;
  logic               passed;
  logic [MS_W-1:0]    ms;
  logic [PROD_W-1:0]  prod;
  logic [OFF_W-1:0]   ticks;
  logic [IDX_W-1:0]   eff_len;
  logic [IDX_W-1:0]   idx_inc;

  assign deadline = base_q + TICK_W'(off_q);
  assign passed   = item_i.now_ticks > deadline;
  assign ms       = (phase_q == PH_START) ? note_i.duration_ms : note_i.pause_ms;
  assign prod     = PROD_W'(ms) * PROD_W'(cfg_i.scale);
  assign ticks    = OFF_W'(prod >> SCALE_SHIFT);
  assign eff_len  = (int'(cfg_i.melody_length) > MAX_NOTES) ? IDX_W'(MAX_NOTES)
                                                            : IDX_W'(cfg_i.melody_length);
  assign idx_inc  = idx_q + IDX_W'(1);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    base_d  = base_q;
    off_d   = off_q;
    freq_d  = freq_q;
    duty_d  = duty_q;
    run_d   = run_q;
    rej     = 1'b0;
    case (item_i.func)
      FUNC_STEP: begin
        case (phase_q)
          PH_START: begin
            base_d  = item_i.now_ticks;
            off_d   = ticks;
            freq_d  = note_i.freq_hz;
            duty_d  = note_i.duty_us;
            run_d   = 1'b1;
            phase_d = PH_PLAY;
          end
          PH_PLAY: begin
            if (passed) begin
              base_d  = deadline;
              off_d   = ticks;
              run_d   = 1'b0;
              phase_d = PH_PAUSE;
            end
          end
          PH_PAUSE: begin
            if (passed) begin
              idx_d   = idx_inc;
              phase_d = (idx_inc >= eff_len) ? PH_STOP : PH_START;
            end
          end
          PH_STOP: begin
            run_d   = 1'b0;
            phase_d = PH_IDLE;
          end
          default: ;
        endcase
      end
      FUNC_START: begin
        if (cfg_i.melody_length == '0) begin
          rej = 1'b1;
        end else begin
          idx_d   = '0;
          phase_d = PH_START;
        end
      end
      FUNC_STOP:  phase_d = PH_STOP;
      FUNC_WRITE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      base_q  <= '0;
      off_q   <= '0;
      freq_q  <= '0;
      duty_q  <= '0;
      run_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      base_q  <= base_d;
      off_q   <= off_d;
      freq_q  <= freq_d;
      duty_q  <= duty_d;
      run_q   <= run_d;
    end
  end

  // forward the index of a transaction retiring in the same cycle
  assign rd_addr_o = adv_i ? idx_d : idx_q;

  assign result_o.tone_freq_hz   = freq_d;
  assign result_o.tone_duty_us   = duty_d;
  assign result_o.tone_on        = run_d;
  assign result_o.phase          = phase_code(phase_d);
  assign result_o.note_position  = idx_d;
  assign result_o.start_rejected = rej;

endmodule

`default_nettype wire

// File: hdl/mts_checker.sv
// Port-level assertions for the melody tone sequencer, bound to the top level.
// Depends on mts_pkg and melody_tone_sequencer.
`default_nettype none

module mts_checker import mts_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input out_item_t              out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped before acceptance");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without an output stall");

  a_tone_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tone_on |->
      out_data_o.phase != CODE_IDLE && out_data_o.phase != CODE_PAUSE)
    else $error("tone running in idle or pause phase");

  a_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_data_o.note_position) <= MAX_NOTES)
    else $error("note position beyond the table");

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: tb/sv/mts_tone_scoreboard_pkg.sv
// Scoreboard for the melody tone sequencer: predicts the tone result of every transaction.
// Depends on mts_pkg for the transaction structs, codes and sizes.
package mts_tone_scoreboard_pkg;
  import mts_pkg::*;

  class tone_scoreboard;
    note_t             notes[MAX_NOTES];
    logic [LEN_W-1:0]  melody_len;
    logic [RATE_W-1:0] rate_hz;
    logic [2:0]        seq_phase;
    logic [IDX_W-1:0]  note_idx;
    logic [TICK_W-1:0] deadline;
    logic [FREQ_W-1:0] freq_hz;
    logic [FREQ_W-1:0] duty_us;
    logic              running;
    out_item_t         expected_tones[$];
    int                errors;

    function new();
      melody_len = '0;
      rate_hz    = RATE_RESET;
      seq_phase  = CODE_IDLE;
      note_idx   = '0;
      deadline   = '0;
      freq_hz    = '0;
      duty_us    = '0;
      running    = 1'b0;
      errors     = 0;
      foreach (notes[i]) notes[i] = '0;
    endfunction

    function int pending();
      return expected_tones.size();
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_LENGTH: melody_len = value[LEN_W-1:0];
        REG_RATE:   rate_hz = value[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [TICK_W-1:0] ms_ticks(logic [MS_W-1:0] ms);
      logic [63:0] prod;
      prod = 64'(ms) * 64'(rate_hz);
      return TICK_W'(prod / 64'd1000);
    endfunction

    function note_t note_at(logic [IDX_W-1:0] idx);
      note_t n;
      n = '0;
      if (idx < MAX_NOTES) n = notes[idx[NOTE_AW-1:0]];
      return n;
    endfunction

    function void step_phase(logic [TICK_W-1:0] now);
      note_t n;
      int    eff_len;
      eff_len = (melody_len > MAX_NOTES) ? MAX_NOTES : int'(melody_len);
      case (seq_phase)
        CODE_START: begin
          n         = note_at(note_idx);
          deadline  = now + ms_ticks(n.duration_ms);
          freq_hz   = n.freq_hz;
          duty_us   = n.duty_us;
          running   = 1'b1;
          seq_phase = CODE_PLAY;
        end
        CODE_PLAY: if (now > deadline) begin
          n         = note_at(note_idx);
          deadline  = deadline + ms_ticks(n.pause_ms);
          running   = 1'b0;
          seq_phase = CODE_PAUSE;
        end
        CODE_PAUSE: if (now > deadline) begin
          note_idx  = note_idx + IDX_W'(1);
          seq_phase = (int'(note_idx) >= eff_len) ? CODE_STOP : CODE_START;
        end
        CODE_STOP: begin
          running   = 1'b0;
          seq_phase = CODE_IDLE;
        end
        default: ;
      endcase
    endfunction

    function void note_transaction(in_item_t it);
      out_item_t tone;
      logic      rejected;
      rejected = 1'b0;
      case (it.func)
        FUNC_STEP: step_phase(it.now_ticks);
        FUNC_START: begin
          if (melody_len == '0) begin
            rejected = 1'b1;
          end else begin
            note_idx  = '0;
            seq_phase = CODE_START;
          end
        end
        FUNC_STOP: seq_phase = CODE_STOP;
        default: begin
          notes[it.entry_index].freq_hz     = it.entry_freq_hz;
          notes[it.entry_index].duty_us     = it.entry_duty_us;
          notes[it.entry_index].duration_ms = it.entry_duration_ms;
          notes[it.entry_index].pause_ms    = it.entry_pause_ms;
        end
      endcase
      tone.tone_freq_hz   = freq_hz;
      tone.tone_duty_us   = duty_us;
      tone.tone_on        = running;
      tone.phase          = seq_phase;
      tone.note_position  = note_idx;
      tone.start_rejected = rejected;
      expected_tones.push_back(tone);
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR: %s", msg);
      errors++;
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    task check_transaction(out_item_t got);
      out_item_t want;
      if (expected_tones.size() == 0) begin
        report($sformatf("tone result %0h with nothing pending", got));
        return;
      end
      want = expected_tones.pop_front();
      compare("tone_freq_hz", 32'(got.tone_freq_hz), 32'(want.tone_freq_hz));
      compare("tone_duty_us", 32'(got.tone_duty_us), 32'(want.tone_duty_us));
      compare("tone_on", 32'(got.tone_on), 32'(want.tone_on));
      compare("phase", 32'(got.phase), 32'(want.phase));
      compare("note_position", 32'(got.note_position), 32'(want.note_position));
      compare("start_rejected", 32'(got.start_rejected), 32'(want.start_rejected));
    endtask
  endclass

endpackage

// File: tb/sv/melody_tone_sequencer_test.sv
// Top of the melody tone sequencer test: clock, reset, handshake drivers and stimulus.
// Depends on mts_pkg, mts_tone_scoreboard_pkg and the melody_tone_sequencer RTL.
module melody_tone_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;
  import mts_tone_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SEG_ITEMS    = 200;
  localparam int unsigned DRAIN_CYCLES = 6;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tone_scoreboard    board = new();
  int unsigned       valid_idle_pct = 0;
  int unsigned       ready_idle_pct = 0;
  bit                hold_req = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       cycle_count = 0;
  logic [TICK_W-1:0] sim_now = '0;

  melody_tone_sequencer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= ready_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_transaction(out_data_o);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("melody_tone_sequencer: mismatch");
    $finish;
  end

  function automatic in_item_t cmd_item(logic [1:0] func, logic [TICK_W-1:0] now);
    in_item_t it;
    it.func              = func;
    it.now_ticks         = now;
    it.entry_index       = ENTRY_IDX_W'($urandom);
    it.entry_freq_hz     = FREQ_W'($urandom);
    it.entry_duty_us     = FREQ_W'($urandom);
    it.entry_duration_ms = MS_W'($urandom);
    it.entry_pause_ms    = MS_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t write_item(logic [ENTRY_IDX_W-1:0] slot, note_t n);
    in_item_t it;
    it                   = cmd_item(FUNC_WRITE, $urandom);
    it.entry_index       = slot;
    it.entry_freq_hz     = n.freq_hz;
    it.entry_duty_us     = n.duty_us;
    it.entry_duration_ms = n.duration_ms;
    it.entry_pause_ms    = n.pause_ms;
    return it;
  endfunction

  function automatic note_t random_note(bit wide);
    note_t n;
    n.freq_hz     = FREQ_W'($urandom);
    n.duty_us     = FREQ_W'($urandom);
    n.duration_ms = wide ? MS_W'($urandom) : MS_W'($urandom_range(0, 60));
    n.pause_ms    = wide ? MS_W'($urandom) : MS_W'($urandom_range(0, 30));
    return n;
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < valid_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_transaction(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_segment(int unsigned count);
    in_item_t    it;
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == 50) hold_req = 1'b1;
      if (k == 130) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        it = cmd_item(FUNC_START, $urandom);
      end else if (pick < 7) begin
        it = cmd_item(FUNC_STOP, $urandom);
      end else if (pick < 15) begin
        it = write_item(ENTRY_IDX_W'($urandom), random_note($urandom_range(0, 9) == 0));
      end else if (pick < 20) begin
        it = cmd_item(FUNC_STEP, $urandom);
      end else begin
        if (pick < 22) sim_now = 32'hFFFF_FFFF - TICK_W'($urandom_range(0, 40));
        else sim_now = sim_now + TICK_W'($urandom_range(0, 8));
        it = cmd_item(FUNC_STEP, sim_now);
      end
      send_item(it);
    end
  endtask

  initial begin : stimulus
    note_t             n;
    logic [LEN_W-1:0]  len;
    logic [RATE_W-1:0] rate;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    valid_idle_pct = 23;
    ready_idle_pct = 85;
    // fill the whole table before anything can play
    for (int i = 0; i < MAX_NOTES; i++) begin
      if (i == 0) n = '1;
      else if (i == 1) n = '0;
      else n = random_note(i % 8 == 3);
      send_item(write_item(ENTRY_IDX_W'(i), n));
    end

    send_item(cmd_item(FUNC_START, $urandom));
    send_item(cmd_item(FUNC_STEP, 32'd5));
    send_item(cmd_item(FUNC_STOP, $urandom));
    send_item(cmd_item(FUNC_STEP, 32'd0));
    wait_drained();
    reg_write(REG_LENGTH, 32'd3);
    reg_write(REG_RATE, 32'd100);
    send_item(cmd_item(FUNC_START, $urandom));
    send_item(cmd_item(FUNC_STEP, 32'hFFFF_F000));
    send_item(cmd_item(FUNC_STEP, 32'h0000_0998));
    send_item(cmd_item(FUNC_STEP, 32'hFFFF_FFFF));
    send_item(cmd_item(FUNC_STEP, 32'd0));
    send_item(cmd_item(FUNC_STEP, 32'hFFFF_FFFF));
    send_item(cmd_item(FUNC_STEP, 32'd100));
    send_item(cmd_item(FUNC_STEP, 32'd100));
    send_item(cmd_item(FUNC_STEP, 32'd101));
    send_item(cmd_item(FUNC_START, $urandom));
    send_item(cmd_item(FUNC_STEP, 32'd7));
    send_item(cmd_item(FUNC_STOP, $urandom));
    send_item(cmd_item(FUNC_STEP, 32'd7));
    send_item(write_item(ENTRY_IDX_W'(5), random_note(1'b1)));
    send_item(cmd_item(FUNC_STEP, $urandom));
    send_item(cmd_item(FUNC_START, $urandom));
    send_item(cmd_item(FUNC_STEP, 32'd10));
    // shorten the melody under the playing note
    wait_drained();
    reg_write(REG_LENGTH, 32'd1);
    repeat (3) send_item(cmd_item(FUNC_STEP, 32'hFFFF_FFFF));

    for (int mode = 0; mode < 3; mode++) begin
      valid_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 85 : 0;
      ready_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 23 : 0;
      for (int part = 0; part < 3; part++) begin
        case (mode * 3 + part)
          0: begin len = 6'd4; rate = 10'd100; end
          1: begin len = 6'd32; rate = 10'd1000; end
          2: begin len = 6'd63; rate = 10'd0; end
          3: begin len = 6'd1; rate = 10'd1; end
          4: begin len = 6'd33; rate = 10'd1023; end
          5: begin len = 6'd2; rate = RATE_W'($urandom_range(1, 1000)); end
          6: begin len = LEN_W'($urandom); rate = RATE_W'($urandom); end
          7: begin len = 6'd0; rate = 10'd500; end
          default: begin
            len  = LEN_W'($urandom_range(1, 32));
            rate = RATE_W'($urandom_range(1, 1000));
          end
        endcase
        wait_drained();
        reg_write(REG_LENGTH, APB_DW'(len));
        reg_write(REG_RATE, APB_DW'(rate));
        run_segment(SEG_ITEMS);
      end
    end

    wait_drained();
    if (board.pending() != 0) board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.errors == 0) begin
      $display("melody_tone_sequencer: match");
    end else begin
      $display("melody_tone_sequencer: mismatch");
    end
    $finish;
  end

endmodule
